// ===== rtl/cwts_pkg.sv =====
// Shared types, field widths and codes of the task wake-up scheduler.
package cwts_pkg;

  localparam int FUNC_W     = 2;
  localparam int TICK_W     = 32;
  localparam int SLOT_IDX_W = 4;
  localparam int STATUS_W   = 3;

  localparam logic [FUNC_W-1:0] FUNC_PICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_YIELD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_STARTING = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RUNNING  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOW      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CTXSW    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WAIT     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_SYNCWAIT = 3'd5;
  localparam logic [STATUS_W-1:0] ST_SLEEPING = 3'd6;
  localparam logic [STATUS_W-1:0] ST_TIMEOUT  = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0]     func;
    logic [TICK_W-1:0]     now_tick;
    logic [SLOT_IDX_W-1:0] slot_index;
    logic [STATUS_W-1:0]   new_status;
    logic [TICK_W-1:0]     time_value;
    logic [TICK_W-1:0]     nice_ticks;
    logic                  present_flag;
  } cwts_req_t;

  typedef struct packed {
    logic                  found;
    logic [SLOT_IDX_W-1:0] chosen_slot;
    logic [TICK_W-1:0]     sleep_ticks;
    logic [TICK_W-1:0]     late_ticks;
    logic [STATUS_W-1:0]   chosen_status;
  } cwts_rsp_t;

  typedef struct packed {
    logic accept;
    logic walk;
    logic commit;
    logic exec;
  } cwts_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] req_func;
    logic              any_present;
    logic              walk_stop;
    logic              walk_have;
    logic              out_free;
  } cwts_stat_t;

endpackage

// ===== rtl/cwts_req_if.sv =====
// Request channel of the task wake-up scheduler.
interface cwts_req_if import cwts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [FUNC_W-1:0]     func;
  logic [TICK_W-1:0]     now_tick;
  logic [SLOT_IDX_W-1:0] slot_index;
  logic [STATUS_W-1:0]   new_status;
  logic [TICK_W-1:0]     time_value;
  logic [TICK_W-1:0]     nice_ticks;
  logic                  present_flag;

  modport source (
    output valid, func, now_tick, slot_index, new_status, time_value, nice_ticks,
           present_flag,
    input  ready
  );
  modport sink (
    input  valid, func, now_tick, slot_index, new_status, time_value, nice_ticks,
           present_flag,
    output ready
  );
endinterface

// ===== rtl/cwts_rsp_if.sv =====
// Response channel of the task wake-up scheduler.
interface cwts_rsp_if import cwts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  found;
  logic [SLOT_IDX_W-1:0] chosen_slot;
  logic [TICK_W-1:0]     sleep_ticks;
  logic [TICK_W-1:0]     late_ticks;
  logic [STATUS_W-1:0]   chosen_status;

  modport source (
    output valid, found, chosen_slot, sleep_ticks, late_ticks, chosen_status,
    input  ready
  );
  modport sink (
    input  valid, found, chosen_slot, sleep_ticks, late_ticks, chosen_status,
    output ready
  );
endinterface

// ===== rtl/cwts_ctrl.sv =====
// Controller state machine: sequences accept, slot walk, commit and plain operations.
module cwts_ctrl import cwts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cwts_stat_t stat_i,
  output cwts_cmd_t  cmd_o
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_COMMIT, S_EXEC} state_e;

  state_e state_q, state_d;
  logic   rdy_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && rdy_q) begin
          cmd_o.accept = 1'b1;
          if (stat_i.req_func == FUNC_PICK && stat_i.any_present) begin
            state_d = S_WALK;
          end else begin
            state_d = S_EXEC;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (stat_i.walk_stop) begin
          state_d = stat_i.walk_have ? S_COMMIT : S_EXEC;
        end
      end
      S_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      state_q <= state_d;
      rdy_q   <= (state_d == S_IDLE);
    end
  end

  assign in_ready_o = rdy_q;

endmodule

// ===== rtl/cwts_dp.sv =====
// Datapath: task table memories, ring walk, candidate registers and result register.
module cwts_dp import cwts_pkg::*; #(
  parameter int TASK_SLOTS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cwts_cmd_t  cmd_i,
  output cwts_stat_t stat_o,
  input  cwts_req_t  req_i,
  input  logic       rsp_ready_i,
  output logic       rsp_valid_o,
  output cwts_rsp_t  rsp_o
);

  localparam int SW = $clog2(TASK_SLOTS);

  typedef logic [SW-1:0]        slot_t;
  typedef logic [TIME_BITS-1:0] tick_t;

  // First present slot after 'from' in ring order.
  function automatic slot_t next_present(slot_t from, logic [TASK_SLOTS-1:0] pres);
    logic [TASK_SLOTS-1:0] above;
    slot_t                 lo_all;
    slot_t                 lo_above;
    above    = '0;
    lo_all   = '0;
    lo_above = '0;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      above[i] = pres[i] && (i > int'(from));
    end
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (pres[i]) lo_all = slot_t'(i);
      if (above[i]) lo_above = slot_t'(i);
    end
    return (|above) ? lo_above : lo_all;
  endfunction

  // Task table.
  logic [STATUS_W-1:0] st_mem   [TASK_SLOTS];
  tick_t               wake_mem [TASK_SLOTS];
  tick_t               nice_mem [TASK_SLOTS];

  logic [TASK_SLOTS-1:0] present_q;
  slot_t                 cur_q;
  logic                  cur_valid_q;
  logic                  have_q;
  logic                  out_valid_q;

  logic [FUNC_W-1:0]     func_q;
  tick_t                 now_q;
  logic [SLOT_IDX_W-1:0] slot_q;
  logic [STATUS_W-1:0]   ns_q;
  tick_t                 tv_q;
  tick_t                 nice_in_q;
  logic                  pres_q;

  slot_t               first_q;
  slot_t               eval_pos_q;
  logic [STATUS_W-1:0] rd_st_q;
  tick_t               rd_wake_q;
  tick_t               nice_rd_q;

  slot_t               cand_q;
  tick_t               cand_wake_q;
  logic [STATUS_W-1:0] cand_st_q;
  logic                cand_imm_q;

  cwts_rsp_t rsp_q;

  slot_t start_pos;
  slot_t np;
  logic  rd_en;
  logic  more;

  logic  waitlike;
  logic  compet;
  logic  imm;
  logic  skip;
  logic  take;
  tick_t new_wake;
  logic  new_have;
  logic  stop;

  logic [STATUS_W-1:0] pick_ns;
  tick_t               diff_sleep;
  tick_t               diff_late;

  tick_t               tv_or_nice;
  tick_t               y_wake;
  logic [STATUS_W-1:0] y_st;
  logic                slot_ok;
  slot_t               slot_addr;

  logic                st_we;
  logic                wake_we;
  logic                nice_we;
  logic                pres_we;
  slot_t               wr_addr;
  logic [STATUS_W-1:0] st_wd;
  tick_t               wake_wd;

  // Walk addressing: at accept the walk starts after the current slot.
  assign start_pos = cur_valid_q ? cur_q : slot_t'(TASK_SLOTS - 1);
  assign np        = next_present(cmd_i.accept ? start_pos : eval_pos_q, present_q);
  assign rd_en     = cmd_i.accept || cmd_i.walk;
  assign more      = (np != first_q);

  // Evaluation of the slot whose entry was read last cycle.
  always_comb begin
    waitlike = (rd_st_q inside {ST_WAIT, ST_SYNCWAIT});
    compet   = waitlike || (rd_st_q == ST_SLEEPING);
    imm      = !compet;
    skip     = waitlike && (rd_wake_q == '0);
    take     = imm || (compet && !skip && (!have_q || (cand_wake_q > rd_wake_q)));
    if (imm) begin
      new_wake = now_q;
    end else if (take) begin
      new_wake = rd_wake_q;
    end else begin
      new_wake = cand_wake_q;
    end
    new_have = have_q || take;
    stop     = imm || (compet && !skip && (new_wake <= now_q)) || !more;
  end

  always_comb begin
    pick_ns    = (cand_st_q inside {ST_WAIT, ST_SYNCWAIT}) ? ST_TIMEOUT : ST_RUNNING;
    diff_sleep = (cand_wake_q > now_q) ? (cand_wake_q - now_q) : '0;
    diff_late  = (cand_wake_q > now_q) ? '0 : (now_q - cand_wake_q);
  end

  // Yield: new wake time and status of the current task.
  always_comb begin
    tv_or_nice = (tv_q != '0) ? tv_q : nice_rd_q;
    y_st       = ns_q;
    case (ns_q)
      ST_CTXSW: begin
        y_wake = now_q + tv_or_nice;
        y_st   = ST_SLEEPING;
      end
      ST_WAIT, ST_SYNCWAIT: y_wake = (tv_q == '0) ? '0 : (now_q + tv_q);
      ST_SLEEPING:          y_wake = now_q + tv_q;
      default:              y_wake = now_q;
    endcase
  end

  assign slot_ok   = ({4'b0, slot_q} < 8'(TASK_SLOTS));
  assign slot_addr = slot_t'(slot_q);

  // Table write port.
  always_comb begin
    st_we   = 1'b0;
    wake_we = 1'b0;
    nice_we = 1'b0;
    pres_we = 1'b0;
    wr_addr = cand_q;
    st_wd   = pick_ns;
    wake_wd = now_q;
    if (cmd_i.commit) begin
      st_we   = 1'b1;
      wake_we = cand_imm_q;
    end else if (cmd_i.exec) begin
      if (func_q == FUNC_YIELD && cur_valid_q) begin
        wr_addr = cur_q;
        st_we   = 1'b1;
        wake_we = 1'b1;
        st_wd   = y_st;
        wake_wd = y_wake;
      end else if (func_q == FUNC_WRITE && slot_ok) begin
        wr_addr = slot_addr;
        st_we   = 1'b1;
        wake_we = 1'b1;
        nice_we = 1'b1;
        pres_we = 1'b1;
        st_wd   = ns_q;
        wake_wd = tv_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[wr_addr] <= st_wd;
    if (wake_we) wake_mem[wr_addr] <= wake_wd;
    if (nice_we) nice_mem[wr_addr] <= nice_in_q;
    if (rd_en) begin
      rd_st_q   <= st_mem[np];
      rd_wake_q <= wake_mem[np];
    end
    if (cmd_i.accept) nice_rd_q <= nice_mem[cur_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        have_q <= 1'b0;
      end else if (cmd_i.walk) begin
        have_q <= new_have;
      end
      if (pres_we) present_q[slot_addr] <= pres_q;
      if (cmd_i.commit) begin
        cur_q       <= cand_q;
        cur_valid_q <= 1'b1;
      end
      if (cmd_i.commit || cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q     <= req_i.func;
      now_q      <= tick_t'(req_i.now_tick);
      slot_q     <= req_i.slot_index;
      ns_q       <= req_i.new_status;
      tv_q       <= tick_t'(req_i.time_value);
      nice_in_q  <= tick_t'(req_i.nice_ticks);
      pres_q     <= req_i.present_flag;
      first_q    <= np;
      eval_pos_q <= np;
    end else if (cmd_i.walk) begin
      eval_pos_q <= np;
      if (take) begin
        cand_q      <= eval_pos_q;
        cand_wake_q <= new_wake;
        cand_st_q   <= rd_st_q;
        cand_imm_q  <= imm;
      end
    end
    if (cmd_i.commit) begin
      rsp_q.found         <= 1'b1;
      rsp_q.chosen_slot   <= SLOT_IDX_W'(cand_q);
      rsp_q.sleep_ticks   <= TICK_W'(diff_sleep);
      rsp_q.late_ticks    <= TICK_W'(diff_late);
      rsp_q.chosen_status <= pick_ns;
    end else if (cmd_i.exec) begin
      rsp_q <= '0;
    end
  end

  assign stat_o.req_func    = req_i.func;
  assign stat_o.any_present = |present_q;
  assign stat_o.walk_stop   = stop;
  assign stat_o.walk_have   = new_have;
  assign stat_o.out_free    = !out_valid_q || rsp_ready_i;

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = rsp_q;

endmodule

// ===== rtl/cooperative_task_wakeup_scheduler.sv =====
// Top level of the cooperative task wake-up scheduler.
//
// One request channel (req_i) and one response channel (rsp_o), each a
// valid/ready interface; a word moves at a clock edge with valid and ready high.
// Every request word gives exactly one response word. A pick (func 0) walks the
// present task slots in ring order after the current slot, one slot per cycle,
// since each step reads the single-ported task table; the walk visits at most
// the number of present slots, so at most TASK_SLOTS. Yield (func 1), slot
// write (func 2), the unused code and a pick with no present slot skip the walk.
// One request is worked on at a time; ready rises again once the result sits
// in the output register. If the receiver stalls, the finished word waits in
// the output register and the block still takes the next request, holding its
// result until the register frees. Reset detaches every slot and clears the
// current task, so the first pick starts at the lowest present slot.
module cooperative_task_wakeup_scheduler import cwts_pkg::*; #(
  parameter int TASK_SLOTS = 16,
  parameter int TIME_BITS  = 32
) (
  input logic       clk_i,
  input logic       rst_ni,
  cwts_req_if.sink   req_i,
  cwts_rsp_if.source rsp_o
);

  cwts_cmd_t  cmd;
  cwts_stat_t stat;
  cwts_req_t  req;
  cwts_rsp_t  rsp;
  logic       rsp_valid;

  assign req.func         = req_i.func;
  assign req.now_tick     = req_i.now_tick;
  assign req.slot_index   = req_i.slot_index;
  assign req.new_status   = req_i.new_status;
  assign req.time_value   = req_i.time_value;
  assign req.nice_ticks   = req_i.nice_ticks;
  assign req.present_flag = req_i.present_flag;

  cwts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  cwts_dp #(
    .TASK_SLOTS (TASK_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .req_i       (req),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp)
  );

  assign rsp_o.valid         = rsp_valid;
  assign rsp_o.found         = rsp.found;
  assign rsp_o.chosen_slot   = rsp.chosen_slot;
  assign rsp_o.sleep_ticks   = rsp.sleep_ticks;
  assign rsp_o.late_ticks    = rsp.late_ticks;
  assign rsp_o.chosen_status = rsp.chosen_status;

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.walk, cmd.commit, cmd.exec}))
    else $error("more than one controller command in a cycle");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while a word is still in work");

  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> (rsp_o.valid && rsp_o.found))
    else $error("pick commit did not present a found result");

  a_exec_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.exec |=> (rsp_o.valid && !rsp_o.found))
    else $error("plain operation did not present an empty result");

endmodule

// ===== dv/cwts_sched_checker.sv =====
// Checker that predicts every scheduler response word and compares it with the one observed.
module cwts_sched_checker import cwts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cwts_req_if        req_mon,
  cwts_rsp_if        rsp_mon,
  output int         mismatch_count_o,
  output int         words_due_o
);

  localparam int NUM_SLOTS = 16;

  logic [STATUS_W-1:0] slot_status   [NUM_SLOTS];
  logic [TICK_W-1:0]   slot_wake     [NUM_SLOTS];
  logic [TICK_W-1:0]   slot_nice     [NUM_SLOTS];
  logic                slot_attached [NUM_SLOTS];
  int unsigned         run_slot;
  logic                run_valid;

  cwts_rsp_t owed_results_q [$];
  cwts_req_t taken_word;
  cwts_rsp_t seen_word;
  cwts_rsp_t owed_word;
  cwts_rsp_t next_owed;

  // Applies one request word to the scheduler state and returns the response it owes.
  task automatic schedule_step(input cwts_req_t w, output cwts_rsp_t r);
    int unsigned         live;
    int unsigned         pos;
    int unsigned         cand;
    int unsigned         k;
    logic                have;
    logic                stop;
    logic [STATUS_W-1:0] st;
    logic [STATUS_W-1:0] st_new;
    logic [TICK_W-1:0]   wk;
    r = '0;
    case (w.func)
      FUNC_PICK: begin
        live = 0;
        for (k = 0; k < NUM_SLOTS; k++) begin
          if (slot_attached[k]) live++;
        end
        pos  = run_valid ? run_slot : NUM_SLOTS - 1;
        cand = 0;
        have = 1'b0;
        stop = 1'b0;
        for (k = 0; k < live && !stop; k++) begin
          // Advance to the next attached slot in ring order; one always exists here.
          do pos = (pos + 1) % NUM_SLOTS; while (!slot_attached[pos]);
          st = slot_status[pos];
          if (st == ST_WAIT || st == ST_SYNCWAIT || st == ST_SLEEPING) begin
            // A waiting task with no wake time waits indefinitely and is passed over.
            if (st == ST_SLEEPING || slot_wake[pos] != '0) begin
              if (!have || slot_wake[cand] > slot_wake[pos]) begin
                cand = pos;
                have = 1'b1;
              end
              stop = (slot_wake[cand] <= w.now_tick);
            end
          end else begin
            cand = pos;
            have = 1'b1;
            slot_wake[pos] = w.now_tick;
            stop = 1'b1;
          end
        end
        if (have) begin
          wk = slot_wake[cand];
          st_new = (slot_status[cand] == ST_WAIT || slot_status[cand] == ST_SYNCWAIT) ?
                   ST_TIMEOUT : ST_RUNNING;
          r.found = 1'b1;
          r.chosen_slot = SLOT_IDX_W'(cand);
          if (wk > w.now_tick) r.sleep_ticks = wk - w.now_tick;
          else r.late_ticks = w.now_tick - wk;
          r.chosen_status = st_new;
          slot_status[cand] = st_new;
          run_slot = cand;
          run_valid = 1'b1;
        end
      end
      FUNC_YIELD: begin
        if (run_valid) begin
          st_new = w.new_status;
          case (w.new_status)
            ST_CTXSW: begin
              wk = w.now_tick + ((w.time_value != '0) ? w.time_value : slot_nice[run_slot]);
              st_new = ST_SLEEPING;
            end
            ST_WAIT, ST_SYNCWAIT: wk = (w.time_value != '0) ? w.now_tick + w.time_value : '0;
            ST_SLEEPING: wk = w.now_tick + w.time_value;
            default: wk = w.now_tick;
          endcase
          slot_wake[run_slot] = wk;
          slot_status[run_slot] = st_new;
        end
      end
      FUNC_WRITE: begin
        // The slot index cannot leave the table with sixteen slots.
        slot_status[w.slot_index]   = w.new_status;
        slot_wake[w.slot_index]     = w.time_value;
        slot_nice[w.slot_index]     = w.nice_ticks;
        slot_attached[w.slot_index] = w.present_flag;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_status[i]   = '0;
        slot_wake[i]     = '0;
        slot_nice[i]     = '0;
        slot_attached[i] = 1'b0;
      end
      run_slot = 0;
      run_valid = 1'b0;
      owed_results_q.delete();
      mismatch_count_o = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        seen_word.found         = rsp_mon.found;
        seen_word.chosen_slot   = rsp_mon.chosen_slot;
        seen_word.sleep_ticks   = rsp_mon.sleep_ticks;
        seen_word.late_ticks    = rsp_mon.late_ticks;
        seen_word.chosen_status = rsp_mon.chosen_status;
        // Fields are shown as found/slot/sleep/late/status.
        if (owed_results_q.size() == 0) begin
          mismatch_count_o++;
          if (mismatch_count_o <= 10)
            $display("%0t: response word with none owed: %0b/%0d/%h/%h/%0d",
                     $time, seen_word.found, seen_word.chosen_slot, seen_word.sleep_ticks,
                     seen_word.late_ticks, seen_word.chosen_status);
        end else begin
          owed_word = owed_results_q.pop_front();
          if (seen_word.found !== owed_word.found ||
              seen_word.chosen_slot !== owed_word.chosen_slot ||
              seen_word.sleep_ticks !== owed_word.sleep_ticks ||
              seen_word.late_ticks !== owed_word.late_ticks ||
              seen_word.chosen_status !== owed_word.chosen_status) begin
            mismatch_count_o++;
            if (mismatch_count_o <= 10)
              $display("%0t: response mismatch: expected %0b/%0d/%h/%h/%0d, got %0b/%0d/%h/%h/%0d",
                       $time, owed_word.found, owed_word.chosen_slot, owed_word.sleep_ticks,
                       owed_word.late_ticks, owed_word.chosen_status, seen_word.found,
                       seen_word.chosen_slot, seen_word.sleep_ticks, seen_word.late_ticks,
                       seen_word.chosen_status);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        taken_word.func         = req_mon.func;
        taken_word.now_tick     = req_mon.now_tick;
        taken_word.slot_index   = req_mon.slot_index;
        taken_word.new_status   = req_mon.new_status;
        taken_word.time_value   = req_mon.time_value;
        taken_word.nice_ticks   = req_mon.nice_ticks;
        taken_word.present_flag = req_mon.present_flag;
        schedule_step(taken_word, next_owed);
        owed_results_q.push_back(next_owed);
      end
    end
    words_due_o = owed_results_q.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the scheduler testbench: clock, reset, request and response traffic, and the verdict.
module tb_top;
  import cwts_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam logic [TICK_W-1:0] TICK_MAX    = '1;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #2 clk_i = ~clk_i;

  cwts_req_if req_ch ();
  cwts_rsp_if rsp_ch ();

  int mismatches;
  int words_due;
  int src_idle_pct;
  int snk_stall_pct;
  logic [TICK_W-1:0] tick_base;

  cooperative_task_wakeup_scheduler DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  cwts_sched_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_mon          (req_ch),
    .rsp_mon          (rsp_ch),
    .mismatch_count_o (mismatches),
    .words_due_o      (words_due)
  );

  function automatic cwts_req_t req_word(input logic [FUNC_W-1:0] f,
                                         input logic [TICK_W-1:0] now,
                                         input logic [SLOT_IDX_W-1:0] slot,
                                         input logic [STATUS_W-1:0] st,
                                         input logic [TICK_W-1:0] tv,
                                         input logic [TICK_W-1:0] nice,
                                         input logic pres);
    cwts_req_t w;
    w.func         = f;
    w.now_tick     = now;
    w.slot_index   = slot;
    w.new_status   = st;
    w.time_value   = tv;
    w.nice_ticks   = nice;
    w.present_flag = pres;
    return w;
  endfunction

  // Mostly an orderly run of picks and yields on a ticking clock, with table writes,
  // clock jumps (some near the wrap point), and a few unused codes.
  function automatic cwts_req_t scheduler_traffic_word();
    cwts_req_t   w;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) tick_base = $urandom;
    else if (roll < 5) tick_base = TICK_MAX - TICK_W'($urandom_range(0, 200));
    else tick_base = tick_base + TICK_W'($urandom_range(0, 60));
    w.now_tick     = tick_base;
    w.slot_index   = SLOT_IDX_W'($urandom_range(0, 15));
    w.new_status   = STATUS_W'($urandom_range(0, 7));
    w.nice_ticks   = ($urandom_range(0, 3) == 0) ? $urandom : TICK_W'($urandom_range(0, 100));
    w.present_flag = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 3))
      0:       w.time_value = '0;
      3:       w.time_value = $urandom;
      default: w.time_value = TICK_W'($urandom_range(1, 200));
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 42) begin
      w.func = FUNC_PICK;
    end else if (roll < 78) begin
      w.func = FUNC_YIELD;
    end else if (roll < 96) begin
      w.func = FUNC_WRITE;
      // A written wake time is absolute: soon, overdue, unset or anywhere.
      case ($urandom_range(0, 4))
        0:       w.time_value = '0;
        1:       w.time_value = tick_base - TICK_W'($urandom_range(0, 300));
        2:       w.time_value = $urandom;
        default: w.time_value = tick_base + TICK_W'($urandom_range(0, 300));
      endcase
    end else begin
      w.func = FUNC_UNUSED;
    end
    return w;
  endfunction

  task automatic send_word(input cwts_req_t w);
    int unsigned gap;
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      req_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    req_ch.valid        <= 1'b1;
    req_ch.func         <= w.func;
    req_ch.now_tick     <= w.now_tick;
    req_ch.slot_index   <= w.slot_index;
    req_ch.new_status   <= w.new_status;
    req_ch.time_value   <= w.time_value;
    req_ch.nice_ticks   <= w.nice_ticks;
    req_ch.present_flag <= w.present_flag;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Response side: random stall bursts while the current phase allows them.
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (snk_stall_pct != 0 && $urandom_range(0, 99) < snk_stall_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk_i);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int idle_plan  [5];
    int stall_plan [5];
    idle_plan  = '{20, 0, 45, 10, 0};
    stall_plan = '{8, 0, 15, 4, 0};
    rst_ni              = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.func         = '0;
    req_ch.now_tick     = '0;
    req_ch.slot_index   = '0;
    req_ch.new_status   = '0;
    req_ch.time_value   = '0;
    req_ch.nice_ticks   = '0;
    req_ch.present_flag = 1'b0;
    src_idle_pct        = 25;
    snk_stall_pct       = 6;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Empty table, a yield with no task running, and an unused code with every field high.
    send_word(req_word(FUNC_PICK, '0, 4'd0, ST_STARTING, '0, '0, 1'b0));
    send_word(req_word(FUNC_YIELD, 32'd100, 4'd0, ST_SLEEPING, 32'd5, '0, 1'b0));
    send_word(req_word(FUNC_UNUSED, TICK_MAX, 4'd15, ST_TIMEOUT, TICK_MAX, TICK_MAX, 1'b1));
    send_word(req_word(FUNC_WRITE, '0, 4'd15, ST_SLEEPING, TICK_MAX, TICK_MAX, 1'b1));
    send_word(req_word(FUNC_WRITE, '0, 4'd3, ST_WAIT, '0, '0, 1'b1));
    send_word(req_word(FUNC_PICK, '0, 4'd0, ST_STARTING, '0, '0, 1'b0));
    // Context switch with no delay given falls back to the nice value and wraps.
    send_word(req_word(FUNC_YIELD, 32'd10, 4'd0, ST_CTXSW, '0, '0, 1'b0));
    send_word(req_word(FUNC_PICK, 32'd5, 4'd0, ST_STARTING, '0, '0, 1'b0));
    send_word(req_word(FUNC_WRITE, '0, 4'd7, ST_STARTING, 32'd123, 32'd50, 1'b1));
    send_word(req_word(FUNC_PICK, 32'd20, 4'd0, ST_STARTING, '0, '0, 1'b0));
    send_word(req_word(FUNC_YIELD, 32'd25, 4'd0, ST_WAIT, '0, '0, 1'b0));
    send_word(req_word(FUNC_WRITE, '0, 4'd3, ST_SYNCWAIT, 32'd30, 32'd1, 1'b1));
    send_word(req_word(FUNC_PICK, 32'd40, 4'd0, ST_STARTING, '0, '0, 1'b0));
    send_word(req_word(FUNC_YIELD, 32'd41, 4'd0, ST_SLEEPING, 32'd1000, '0, 1'b0));
    send_word(req_word(FUNC_PICK, 32'd50, 4'd0, ST_STARTING, '0, '0, 1'b0));
    send_word(req_word(FUNC_YIELD, 32'd60, 4'd0, ST_NOW, '0, '0, 1'b0));
    send_word(req_word(FUNC_YIELD, 32'd61, 4'd0, ST_STARTING, '0, '0, 1'b0));
    send_word(req_word(FUNC_YIELD, 32'd62, 4'd0, ST_RUNNING, '0, '0, 1'b0));
    send_word(req_word(FUNC_YIELD, 32'd63, 4'd0, ST_TIMEOUT, '0, '0, 1'b0));
    send_word(req_word(FUNC_YIELD, 32'd64, 4'd0, ST_SYNCWAIT, '0, '0, 1'b0));
    // Detach the running task; the next walk still starts just past it.
    send_word(req_word(FUNC_WRITE, '0, 4'd3, ST_STARTING, '0, '0, 1'b0));
    send_word(req_word(FUNC_PICK, 32'd70, 4'd0, ST_STARTING, '0, '0, 1'b0));
    // Every attached task now waits indefinitely, so nothing can be chosen.
    send_word(req_word(FUNC_YIELD, TICK_MAX, 4'd0, ST_WAIT, '0, '0, 1'b0));
    send_word(req_word(FUNC_PICK, TICK_MAX, 4'd0, ST_STARTING, '0, '0, 1'b0));
    send_word(req_word(FUNC_YIELD, 32'd2, 4'd0, ST_CTXSW, TICK_MAX, '0, 1'b0));
    send_word(req_word(FUNC_YIELD, 32'd7, 4'd0, ST_WAIT, 32'd5, '0, 1'b0));

    tick_base = TICK_W'($urandom_range(0, 1000));
    for (int ph = 0; ph < 5; ph++) begin
      src_idle_pct  = idle_plan[ph];
      snk_stall_pct = stall_plan[ph];
      repeat (220) send_word(scheduler_traffic_word());
    end
    @(negedge clk_i);
    req_ch.valid <= 1'b0;

    wait (words_due == 0);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && words_due == 0) begin
      $display("** cooperative_task_wakeup_scheduler: PASSED **");
    end else begin
      $display("** cooperative_task_wakeup_scheduler: FAILED **");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("** cooperative_task_wakeup_scheduler: FAILED **");
    $finish;
  end

endmodule
